[rtl/sql_keyword_spotter_unit_assert.svh]
// assertion macros shared by the keyword spotter modules
`ifndef SQL_KEYWORD_SPOTTER_UNIT_ASSERT_SVH
`define SQL_KEYWORD_SPOTTER_UNIT_ASSERT_SVH
// same-cycle implication
`define SKS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SKS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/sqlks_pkg.sv]
// package for the sql keyword spotter: sizes, keyword table and byte helpers
package sqlks_pkg;

   localparam int MAX_WORD      = 17;
   localparam int KEYWORD_COUNT = 121;
   localparam int MAX_LINE      = 65535;
   localparam int KW_STORED     = 121;
   localparam int KW_SLOT       = 17;
   localparam int QUEUE_DEPTH   = 2;
   localparam int START_W       = 16;
   localparam int LENGTH_W      = 5;
   localparam int INDEX_W       = 7;

   typedef struct packed {
      logic [START_W-1:0]  start;
      logic [LENGTH_W-1:0] length;
   } word_rec_type;

   function automatic logic [KW_SLOT*8-1:0] kw_text(input int k);
      logic [KW_SLOT*8-1:0] t;
      case (k)
         0: t = "ABORT";           1: t = "ACTION";        2: t = "ADD";
         3: t = "AFTER";           4: t = "ALL";           5: t = "ALTER";
         6: t = "ANALYZE";         7: t = "AND";           8: t = "AS";
         9: t = "ASC";            10: t = "ATTACH";       11: t = "AUTOINCREMENT";
         12: t = "BEFORE";        13: t = "BEGIN";        14: t = "BETWEEN";
         15: t = "BY";            16: t = "CASCADE";      17: t = "CASE";
         18: t = "CAST";          19: t = "CHECK";        20: t = "COLLATE";
         21: t = "COLUMN";        22: t = "COMMIT";       23: t = "CONFLICT";
         24: t = "CONSTRAINT";    25: t = "CREATE";       26: t = "CROSS";
         27: t = {"CURRENT_", "DATE"};
         28: t = {"CURRENT_", "TIME"};
         29: t = {"CURRENT_", "TIMESTAMP"};
         30: t = "DATABASE";      31: t = "DEFAULT";      32: t = "DEFERRABLE";
         33: t = "DEFERRED";      34: t = "DELETE";       35: t = "DESC";
         36: t = "DETACH";        37: t = "DISTINCT";     38: t = "DROP";
         39: t = "EACH";          40: t = "ELSE";         41: t = "END";
         42: t = "ESCAPE";        43: t = "EXCEPT";       44: t = "EXCLUSIVE";
         45: t = "EXISTS";        46: t = "EXPLAIN";      47: t = "FAIL";
         48: t = "FOR";           49: t = "FOREIGN";      50: t = "FROM";
         51: t = "FULL";          52: t = "GLOB";         53: t = "GROUP";
         54: t = "HAVING";        55: t = "IF";           56: t = "IGNORE";
         57: t = "IMMEDIATE";     58: t = "IN";           59: t = "INDEX";
         60: t = "INDEXED";       61: t = "INITIALLY";    62: t = "INNER";
         63: t = "INSERT";        64: t = "INSTEAD";      65: t = "INTERSECT";
         66: t = "INTO";          67: t = "IS";           68: t = "ISNULL";
         69: t = "JOIN";          70: t = "KEY";          71: t = "LEFT";
         72: t = "LIKE";          73: t = "LIMIT";        74: t = "MATCH";
         75: t = "NATURAL";       76: t = "NO";           77: t = "NOT";
         78: t = "NOTNULL";       79: t = "NULL";         80: t = "OF";
         81: t = "OFFSET";        82: t = "ON";           83: t = "OR";
         84: t = "ORDER";         85: t = "OUTER";        86: t = "PLAN";
         87: t = "PRAGMA";        88: t = "PRIMARY";      89: t = "QUERY";
         90: t = "RAISE";         91: t = "REFERENCES";   92: t = "REGEXP";
         93: t = "REINDEX";       94: t = "RELEASE";      95: t = "RENAME";
         96: t = "REPLACE";       97: t = "RESTRICT";     98: t = "RIGHT";
         99: t = "ROLLBACK";     100: t = "ROW";         101: t = "SAVEPOINT";
         102: t = "SELECT";      103: t = "SET";         104: t = "TABLE";
         105: t = "TEMP";        106: t = "TEMPORARY";   107: t = "THEN";
         108: t = "TO";          109: t = "TRANSACTION"; 110: t = "TRIGGER";
         111: t = "UNION";       112: t = "UNIQUE";      113: t = "UPDATE";
         114: t = "USING";       115: t = "VACUUM";      116: t = "VALUES";
         117: t = "VIEW";        118: t = "VIRTUAL";     119: t = "WHEN";
         120: t = "WHERE";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic int kw_len(input int k);
      logic [KW_SLOT*8-1:0] t;
      int n;
      t = kw_text(k);
      n = 0;
      for (int i = 0; i < KW_SLOT; i++) begin
         if (t[i*8 +: 8] != 8'd0) n = n + 1;
      end
      return n;
   endfunction

   // keyword text with its first character in the top byte
   function automatic logic [KW_SLOT*8-1:0] kw_left(input int k);
      return kw_text(k) << ((KW_SLOT - kw_len(k)) * 8);
   endfunction

   function automatic logic [7:0] kw_char(input logic [KW_SLOT*8-1:0] tl,
                                          input logic [5:0] j);
      logic [7:0] c;
      c = 8'd0;
      for (int i = 0; i < KW_SLOT; i++) begin
         if (j == 6'(i)) c = tl[(KW_SLOT-1-i)*8 +: 8];
      end
      return c;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c == 8'h20 || c == 8'h3b || c == 8'h09 || c == 8'h3d || c == 8'h3e ||
             c == 8'h3c || c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f;
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
   endfunction

endpackage

[rtl/sql_keyword_spotter_unit.sv]
// Keyword spotter: takes one byte of a text line per cycle while req_stall is low (req_line_end
// on the last byte) and reports each word that equals one of 121 SQL keywords, ignoring ASCII
// case. A word's result beat is written into the queue and from there into the output register.
// Per-keyword agreement bits are updated on each accepted byte, and matches wait in a two-entry
// queue, so req_stall rises only while that queue is full, which needs a stalled result side.
module sql_keyword_spotter_unit #(
   parameter int MAX_WORD      = sqlks_pkg::MAX_WORD,
   parameter int KEYWORD_COUNT = sqlks_pkg::KEYWORD_COUNT,
   parameter int MAX_LINE      = sqlks_pkg::MAX_LINE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_char_byte,
   input  logic                           req_line_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sqlks_pkg::START_W-1:0]  rsp_match_start,
   output logic [sqlks_pkg::LENGTH_W-1:0] rsp_match_length,
   output logic [sqlks_pkg::INDEX_W-1:0]  rsp_keyword_index
);
   localparam int VEC_W = (KEYWORD_COUNT < sqlks_pkg::KW_STORED) ?
                          KEYWORD_COUNT : sqlks_pkg::KW_STORED;
   localparam int REC_W = $bits(sqlks_pkg::word_rec_type);
   localparam int Q_W   = REC_W + VEC_W;

   logic                    accept, push, full, avail, pop;
   sqlks_pkg::word_rec_type push_rec, pop_rec;
   logic [VEC_W-1:0]        push_vec, pop_vec;
   logic [Q_W-1:0]          pop_data;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   sqlks_front #(.MAX_WORD(MAX_WORD), .MAX_LINE(MAX_LINE), .VEC_W(VEC_W)) u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .char_byte(req_char_byte), .line_end(req_line_end),
      .push(push), .push_rec(push_rec), .push_vec(push_vec)
   );

   sqlks_queue #(.WIDTH(Q_W), .DEPTH(sqlks_pkg::QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data({push_rec, push_vec}),
      .full(full), .avail(avail), .pop(pop), .pop_data(pop_data)
   );

   assign pop_rec = pop_data[Q_W-1 -: REC_W];
   assign pop_vec = pop_data[VEC_W-1:0];

   sqlks_back #(.VEC_W(VEC_W)) u_back (
      .clock(clock), .reset(reset), .avail(avail), .rec(pop_rec), .vec(pop_vec),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_match_start(rsp_match_start), .rsp_match_length(rsp_match_length),
      .rsp_keyword_index(rsp_keyword_index)
   );
endmodule

[rtl/sqlks_front.sv]
// front end: classifies bytes, tracks the word and its still-matching keyword bits
`include "sql_keyword_spotter_unit_assert.svh"
module sqlks_front #(
   parameter int MAX_WORD = sqlks_pkg::MAX_WORD,
   parameter int MAX_LINE = sqlks_pkg::MAX_LINE,
   parameter int VEC_W    = sqlks_pkg::KEYWORD_COUNT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               char_byte,
   input  logic                     line_end,
   output logic                     push,
   output sqlks_pkg::word_rec_type  push_rec,
   output logic [VEC_W-1:0]         push_vec
);
   localparam int POS_W = $clog2(MAX_LINE + 1);
   localparam int LEN_W = $clog2(MAX_WORD + 1);

   logic              in_word_ff, in_word_in;
   logic [POS_W-1:0]  pos_ff, pos_in, start_ff, start_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              long_ff, long_in;
   logic [VEC_W-1:0]  alive_ff, alive_in, step_hit, cand;
   logic              sep, finish;
   logic [7:0]        fc;
   logic [LEN_W-1:0]  base_len;

   assign sep      = sqlks_pkg::is_sep(char_byte);
   assign fc       = sqlks_pkg::fold(char_byte);
   assign base_len = in_word_ff ? len_ff : '0;

   // keyword k still agrees if its character at the current length equals this byte
   for (genvar k = 0; k < VEC_W; k++) begin : g_kw
      localparam logic [sqlks_pkg::KW_SLOT*8-1:0] TL = sqlks_pkg::kw_left(k);
      localparam int KL = sqlks_pkg::kw_len(k);
      assign step_hit[k] = (6'(base_len) < 6'(KL)) &&
                           (sqlks_pkg::kw_char(TL, 6'(base_len)) == fc);
      assign cand[k] = alive_in[k] && (6'(len_in) == 6'(KL));
   end

   always_comb begin
      in_word_in = !sep;
      start_in   = in_word_ff ? start_ff : pos_ff;
      len_in     = base_len;
      long_in    = in_word_ff ? long_ff : 1'b0;
      alive_in   = in_word_ff ? alive_ff : '1;
      if (!sep) begin
         if (32'(base_len) < MAX_WORD) begin
            len_in   = base_len + 1'b1;
            alive_in = alive_in & step_hit;
         end else begin
            long_in = 1'b1;
         end
      end
   end

   assign finish = (in_word_ff && sep) || (line_end && !sep);
   assign push   = accept && finish && !long_in && (len_in != '0) &&
                   (start_in < POS_W'(MAX_LINE)) && (|cand);
   assign push_rec.start  = sqlks_pkg::START_W'(start_in);
   assign push_rec.length = sqlks_pkg::LENGTH_W'(len_in);
   assign push_vec        = cand;

   assign pos_in = (pos_ff < POS_W'(MAX_LINE)) ? pos_ff + 1'b1 : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         pos_ff     <= '0;
         start_ff   <= '0;
         len_ff     <= '0;
         long_ff    <= 1'b0;
      end else if (accept) begin
         if (line_end) begin
            in_word_ff <= 1'b0;
            pos_ff     <= '0;
            start_ff   <= '0;
            len_ff     <= '0;
            long_ff    <= 1'b0;
         end else begin
            in_word_ff <= in_word_in;
            pos_ff     <= pos_in;
            start_ff   <= start_in;
            len_ff     <= len_in;
            long_ff    <= long_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) alive_ff <= alive_in;
   end

   `SKS_ASSERT_IMP(a_long_full, clock, reset, long_ff, 32'(len_ff) == MAX_WORD,
                   "overlong word without full length")
endmodule

[rtl/sqlks_queue.sv]
// short queue of matched words between front and back
`include "sql_keyword_spotter_unit_assert.svh"
module sqlks_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sqlks_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             avail,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign avail    = cnt_ff != '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      rd_in  = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop)  rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   `SKS_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH),
                   "queue count beyond depth")
   `SKS_ASSERT_IMP(a_no_overrun, clock, reset, push && !pop, !full, "push into full queue")
   `SKS_ASSERT_NEXT(a_cnt_grow, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1,
                    "queue count did not grow on push")
endmodule

[rtl/sqlks_back.sv]
// back end: turns a matched word's keyword bit into its index and holds the result beat
`include "sql_keyword_spotter_unit_assert.svh"
module sqlks_back #(
   parameter int VEC_W = sqlks_pkg::KEYWORD_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               avail,
   input  sqlks_pkg::word_rec_type            rec,
   input  logic [VEC_W-1:0]                   vec,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sqlks_pkg::START_W-1:0]      rsp_match_start,
   output logic [sqlks_pkg::LENGTH_W-1:0]     rsp_match_length,
   output logic [sqlks_pkg::INDEX_W-1:0]      rsp_keyword_index
);
   logic                            valid_ff;
   logic [sqlks_pkg::INDEX_W-1:0]   idx_in, idx_ff;
   sqlks_pkg::word_rec_type         rec_ff;

   // keywords are distinct, so exactly one bit is set and an or of indices is the index
   always_comb begin
      idx_in = '0;
      for (int k = 0; k < VEC_W; k++) begin
         if (vec[k]) idx_in = idx_in | sqlks_pkg::INDEX_W'(k);
      end
   end

   assign pop = avail && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= avail;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= rec;
         idx_ff <= idx_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_match_start   = rec_ff.start;
   assign rsp_match_length  = rec_ff.length;
   assign rsp_keyword_index = idx_ff;

   `SKS_ASSERT_IMP(a_onehot, clock, reset, pop, $onehot(vec), "matched word without single keyword")
endmodule
